// ----- hdl/joystick_axis_conditioner_top_defines.svh -----
// ----------------------------------------------------------------------------
// Joystick axis conditioner assertion macros
// Shared property templates for the conditioner's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_TOP_DEFINES_SVH
`define JOYSTICK_AXIS_CONDITIONER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define JAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define JAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/jac_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick axis conditioner package
// Payload types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package jac_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_CENTER_LX  = 3'd0;
	localparam logic [2:0] CFG_CENTER_LY  = 3'd1;
	localparam logic [2:0] CFG_CENTER_RX  = 3'd2;
	localparam logic [2:0] CFG_CENTER_RY  = 3'd3;
	localparam logic [2:0] CFG_DEAD_BAND  = 3'd4;
	localparam logic [2:0] CFG_CURVE_EXP  = 3'd5;
	localparam logic [2:0] CFG_OUT_SCALE  = 3'd6;
	localparam logic [2:0] CFG_HOLD_MS    = 3'd7;

	// Fixed-point mantissa: Q1.16
	localparam int MANT_W = 17;
	localparam int FRAC_W = 16;
	localparam logic [MANT_W-1:0] MANT_ONE = 17'h10000;
	localparam logic [MANT_W-1:0] MANT_MAX = 17'h1FFFF;
	localparam logic [6:0] MAG_SAT = 7'd127;

	typedef struct packed {
		logic [11:0] sample_left_x;
		logic [11:0] sample_left_y;
		logic [11:0] sample_right_x;
		logic [11:0] sample_right_y;
		logic [1:0]  select_raw;
		logic [9:0]  buttons_raw;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic signed [7:0] left_x;
		logic signed [7:0] left_y;
		logic signed [7:0] right_x;
		logic signed [7:0] right_y;
		logic signed [7:0] rotation;
		logic [9:0]        buttons_out;
		logic [1:0]        select_out;
		logic              changed;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [MANT_W-1:0] mant;
	} log2_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] frac;
	} log2_rsp_t;

endpackage

// ----- hdl/jac_log2.sv -----
// ----------------------------------------------------------------------------
// Joystick axis conditioner log2 fraction unit
// Computes 16 fraction bits of log2 of a Q1.16 mantissa by repeated squaring,
// one squaring per cycle.
// ----------------------------------------------------------------------------
module jac_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  jac_pkg::log2_req_t req,
	output jac_pkg::log2_rsp_t rsp
);

	logic [jac_pkg::MANT_W-1:0] m_q;
	logic [jac_pkg::FRAC_W-1:0] f_q;
	logic [3:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [2*jac_pkg::MANT_W-1:0] sq;
	logic [jac_pkg::MANT_W:0]     sq_hi;

	// Square and renormalize
	assign sq    = m_q * m_q;
	assign sq_hi = sq[2*jac_pkg::MANT_W-1:jac_pkg::FRAC_W];

	// Control: count sixteen squarings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load mantissa, then shift in one fraction bit per squaring
	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q <= req.mant;
			f_q <= '0;
		end else if (busy_q) begin
			f_q <= {f_q[jac_pkg::FRAC_W-2:0], sq_hi[jac_pkg::MANT_W]};
			m_q <= sq_hi[jac_pkg::MANT_W] ? sq_hi[jac_pkg::MANT_W:1]
				: sq_hi[jac_pkg::MANT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.frac = f_q;

endmodule

// ----- hdl/joystick_axis_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// Joystick axis conditioner
// Deadzone and power curve on four stick axes, rotation mode, select
// debouncing and a changed flag, one result per sample set.
// ----------------------------------------------------------------------------
// Usage:
//  sample channel (sample_valid/sample_ready/sample) takes one sample set per
//  transfer; result channel (result_valid/result_ready/result) returns one
//  result per sample. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
//  writes a register; it is always ready. The user must write it only
//  while idle; the block itself does not enforce this. The four axes are
//  conditioned one after another by a single sequencer and one shared log2
//  squaring unit. Per axis: a restoring divide, a leading-one shift, one
//  log2 run and sixteen log2 runs of the exp2 bisection. An axis in the
//  deadzone goes straight from S_DEV to S_NEXT. The log2 runs dominate
//  the time. sample_ready is high only while the sequencer is idle.
//  The result sits in an output register; while the receiver stalls, the
//  next sample set is taken and conditioned but holds in the sequencer,
//  with sample_ready low, until that register has been taken.
//  Reset clears history, debounce state and button register and restores
//  the register defaults.
// ----------------------------------------------------------------------------
`include "joystick_axis_conditioner_top_defines.svh"

module joystick_axis_conditioner_top #(
	parameter int BUTTON_COUNT  = 10,
	parameter int ROTATE_BUTTON = 8,
	parameter int ADC_BITS      = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  jac_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output jac_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int XW = (ADC_BITS > 12) ? ADC_BITS : 12;
	localparam int NW = XW + 16;
	localparam int CW = $clog2(NW);
	localparam logic [XW-1:0] AMASK = XW'((33'd1 << ADC_BITS) - 33'd1);
	localparam logic [XW:0] HALF = (XW+1)'(33'd1 << (ADC_BITS - 1));

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEV    = 4'd1;
	localparam logic [3:0] S_DIV    = 4'd2;
	localparam logic [3:0] S_NORM   = 4'd3;
	localparam logic [3:0] S_LOGW   = 4'd4;
	localparam logic [3:0] S_EXPCHK = 4'd5;
	localparam logic [3:0] S_SRCH   = 4'd6;
	localparam logic [3:0] S_SRCHW  = 4'd7;
	localparam logic [3:0] S_SCALE  = 4'd8;
	localparam logic [3:0] S_SHIFT  = 4'd9;
	localparam logic [3:0] S_NEXT   = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	// Configuration registers
	logic [11:0] center_q [4];
	logic [10:0] dead_band_q;
	logic [15:0] curve_exp_q;
	logic [6:0]  scale_q;
	logic [15:0] hold_ms_q;

	// History state
	logic signed [7:0]       prev_q [5];
	logic [BUTTON_COUNT-1:0] button_q;
	logic [1:0]              sel_deb_q;
	logic [31:0]             sel_time_q [2];

	// Sequencer and datapath
	logic [3:0]              state_q;
	jac_pkg::sample_t        item_q;
	logic [1:0]              ax_q;
	logic signed [7:0]       axres_q [4];
	logic                    pos_q;
	logic [ADC_BITS-1:0]     den_q;
	logic [ADC_BITS-1:0]     rem_q;
	logic [NW-1:0]           dq_q;
	logic [CW-1:0]           cnt_q;
	logic signed [6:0]       lint_q;
	logic signed [39:0]      prod_q;
	logic signed [3:0]       ip_q;
	logic [15:0]             fp_q;
	logic [16:0]             lo_q;
	logic [16:0]             hi_q;
	logic [16:0]             mid_q;
	logic [23:0]             v_q;
	logic [6:0]              mag_q;
	logic                    res_valid_q;
	jac_pkg::result_t        res_q;

	jac_pkg::log2_req_t      lreq;
	jac_pkg::log2_rsp_t      lrsp;

	jac_log2 u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (lreq),
		.rsp   (lrsp)
	);

	// Deviation of the current axis
	logic [11:0]          raw_sel;
	logic [XW-1:0]        raw_m;
	logic signed [XW:0]   dev;
	logic [XW:0]          dev_abs;
	logic [XW-1:0]        ad;
	logic signed [XW:0]   den_full;
	logic [ADC_BITS-1:0]  den_c;

	always_comb begin
		unique case (ax_q)
			2'd0: raw_sel = item_q.sample_left_x;
			2'd1: raw_sel = item_q.sample_left_y;
			2'd2: raw_sel = item_q.sample_right_x;
			default: raw_sel = item_q.sample_right_y;
		endcase
	end

	assign raw_m    = XW'(raw_sel) & AMASK;
	assign dev      = $signed({1'b0, raw_m}) - $signed({1'b0, XW'(center_q[ax_q])});
	assign dev_abs  = dev[XW] ? (XW+1)'(-dev) : dev;
	assign ad       = dev_abs[XW-1:0];
	assign den_full = $signed(HALF) - $signed((XW+1)'(dead_band_q));
	assign den_c    = (den_full < $signed((XW+1)'(1))) ? ADC_BITS'(1)
		: den_full[ADC_BITS-1:0];

	// Restoring divide step
	logic [ADC_BITS:0] trial;
	logic              q_bit;
	assign trial = {rem_q, dq_q[NW-1]};
	assign q_bit = (trial >= {1'b0, den_q});

	// Log2 to power product
	logic signed [22:0] l_val;
	logic signed [39:0] prod_c;
	logic signed [11:0] ip_c;
	assign l_val  = {lint_q, lrsp.frac};
	assign prod_c = l_val * $signed({1'b0, curve_exp_q});
	assign ip_c   = prod_q[39:28];

	// Bisection midpoint
	logic [17:0] mid_sum;
	assign mid_sum = {1'b0, lo_q} + ((({1'b0, hi_q} - {1'b0, lo_q}) + 18'd1) >> 1);

	// Final scale shift and saturation
	logic [29:0] v_sh;
	logic [4:0]  shamt;
	assign shamt = 5'd22 - {ip_q[3], ip_q};
	assign v_sh  = {v_q, 6'b0} >> shamt;

	// Signed axis value, Y axes inverted
	logic signed [7:0] mag_s;
	assign mag_s = $signed({1'b0, mag_q});

	// Log2 requests from normalize and bisection
	always_comb begin
		lreq.start = 1'b0;
		lreq.mant  = dq_q[NW-1 -: jac_pkg::MANT_W];
		if (state_q == S_NORM && dq_q != '0 && dq_q[NW-1]) begin
			lreq.start = 1'b1;
		end else if (state_q == S_SRCH && lo_q < hi_q) begin
			lreq.start = 1'b1;
			lreq.mant  = mid_sum[16:0];
		end
	end

	// Result assembly: debounce, rotation routing, changed flag
	logic [15:0]             btn_wide;
	logic [15:0]             new_wide;
	logic [BUTTON_COUNT-1:0] new_btn;
	logic [15:0]             new_keep;
	logic                    rot;
	logic signed [7:0]       axes [5];
	logic [1:0]              sel_take;
	logic [1:0]              sel_next;
	logic                    chg;

	assign btn_wide = 16'(button_q);
	assign new_wide = {6'b0, item_q.buttons_raw};
	assign new_btn  = new_wide[BUTTON_COUNT-1:0];
	assign new_keep = 16'(new_btn);
	assign rot      = btn_wide[ROTATE_BUTTON];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			sel_take[j] = (item_q.select_raw[j] != sel_deb_q[j]) &&
				((item_q.time_ms - sel_time_q[j]) > 32'(hold_ms_q));
			sel_next[j] = sel_take[j] ? item_q.select_raw[j] : sel_deb_q[j];
		end
		axes[0] = rot ? 8'sd0 : axres_q[0];
		axes[1] = rot ? 8'sd0 : axres_q[1];
		axes[2] = axres_q[2];
		axes[3] = axres_q[3];
		axes[4] = rot ? axres_q[0] : 8'sd0;
		chg = (sel_take != 2'b00) || (new_btn != button_q);
		for (int j = 0; j < 5; j++) begin
			if (axes[j] != prev_q[j]) chg = 1'b1;
		end
	end

	// Handshakes
	assign sample_ready = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) center_q[i] <= 12'd2048;
			dead_band_q <= 11'd100;
			curve_exp_q <= 16'd4096;
			scale_q     <= 7'd127;
			hold_ms_q   <= 16'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jac_pkg::CFG_CENTER_LX: center_q[0] <= cfg_data[11:0];
				jac_pkg::CFG_CENTER_LY: center_q[1] <= cfg_data[11:0];
				jac_pkg::CFG_CENTER_RX: center_q[2] <= cfg_data[11:0];
				jac_pkg::CFG_CENTER_RY: center_q[3] <= cfg_data[11:0];
				jac_pkg::CFG_DEAD_BAND: dead_band_q <= cfg_data[10:0];
				jac_pkg::CFG_CURVE_EXP: curve_exp_q <= cfg_data;
				jac_pkg::CFG_OUT_SCALE: scale_q     <= cfg_data[6:0];
				default:                hold_ms_q   <= cfg_data;
			endcase
		end
	end

	// Sequencer control and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= 2'd0;
			res_valid_q <= 1'b0;
			button_q    <= '0;
			sel_deb_q   <= 2'b00;
			for (int i = 0; i < 2; i++) sel_time_q[i] <= 32'd0;
			for (int i = 0; i < 5; i++) prev_q[i] <= 8'sd0;
		end else begin
			if (res_valid_q && result_ready && state_q != S_DONE) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						ax_q    <= 2'd0;
						state_q <= S_DEV;
					end
				end
				S_DEV: begin
					if (ad < XW'(dead_band_q) || scale_q == '0 || curve_exp_q == '0) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(NW - 1)) state_q <= S_NORM;
				end
				S_NORM: begin
					if (dq_q == '0) state_q <= S_NEXT;
					else if (dq_q[NW-1]) state_q <= S_LOGW;
				end
				S_LOGW: begin
					if (lrsp.done) state_q <= S_EXPCHK;
				end
				S_EXPCHK: begin
					if (ip_c >= 12'sd7 || ip_c <= -12'sd8) state_q <= S_NEXT;
					else state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (lo_q < hi_q) state_q <= S_SRCHW;
					else state_q <= S_SCALE;
				end
				S_SRCHW: begin
					if (lrsp.done) state_q <= S_SRCH;
				end
				S_SCALE: state_q <= S_SHIFT;
				S_SHIFT: state_q <= S_NEXT;
				S_NEXT: begin
					if (ax_q == 2'd3) begin
						state_q <= S_DONE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_DEV;
					end
				end
				S_DONE: begin
					if (!res_valid_q || result_ready) begin
						res_valid_q <= 1'b1;
						button_q    <= new_btn;
						sel_deb_q   <= sel_next;
						for (int j = 0; j < 2; j++) begin
							if (sel_take[j]) sel_time_q[j] <= item_q.time_ms;
						end
						for (int j = 0; j < 5; j++) prev_q[j] <= axes[j];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) item_q <= sample;
			end
			S_DEV: begin
				pos_q <= (dev > $signed((XW+1)'(0)));
				den_q <= den_c;
				rem_q <= '0;
				dq_q  <= {ad, 16'b0};
				cnt_q <= '0;
				if (ad < XW'(dead_band_q) || scale_q == '0) mag_q <= '0;
				else mag_q <= scale_q;
			end
			S_DIV: begin
				rem_q <= q_bit ? ADC_BITS'(trial - {1'b0, den_q}) : trial[ADC_BITS-1:0];
				dq_q  <= {dq_q[NW-2:0], q_bit};
				cnt_q <= (cnt_q == CW'(NW - 1)) ? '0 : cnt_q + CW'(1);
			end
			S_NORM: begin
				if (dq_q == '0) begin
					mag_q <= '0;
				end else if (dq_q[NW-1]) begin
					lint_q <= 7'(NW - 17) - 7'(cnt_q);
				end else begin
					dq_q  <= {dq_q[NW-2:0], 1'b0};
					cnt_q <= cnt_q + CW'(1);
				end
			end
			S_LOGW: begin
				if (lrsp.done) prod_q <= prod_c;
			end
			S_EXPCHK: begin
				ip_q <= ip_c[3:0];
				fp_q <= prod_q[27:12];
				lo_q <= jac_pkg::MANT_ONE;
				hi_q <= jac_pkg::MANT_MAX;
				if (ip_c >= 12'sd7) mag_q <= jac_pkg::MAG_SAT;
				else mag_q <= '0;
			end
			S_SRCH: begin
				mid_q <= mid_sum[16:0];
			end
			S_SRCHW: begin
				if (lrsp.done) begin
					if (lrsp.frac <= fp_q) lo_q <= mid_q;
					else hi_q <= mid_q - 17'd1;
				end
			end
			S_SCALE: begin
				v_q <= scale_q * lo_q;
			end
			S_SHIFT: begin
				mag_q <= (v_sh > 30'd127) ? jac_pkg::MAG_SAT : v_sh[6:0];
			end
			S_NEXT: begin
				axres_q[ax_q] <= (pos_q ^ ax_q[0]) ? mag_s : -mag_s;
			end
			S_DONE: begin
				if (!res_valid_q || result_ready) begin
					res_q.left_x      <= axes[0];
					res_q.left_y      <= axes[1];
					res_q.right_x     <= axes[2];
					res_q.right_y     <= axes[3];
					res_q.rotation    <= axes[4];
					res_q.buttons_out <= new_keep[9:0];
					res_q.select_out  <= sel_next;
					res_q.changed     <= chg;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	`JAC_ASSERT_NEXT(a_busy_after_take, sample_valid && sample_ready, !sample_ready,
		"sample taken but sequencer still ready")
	`JAC_ASSERT_NOW(a_rotation_exclusive, result_valid,
		result.rotation == 8'sd0 || (result.left_x == 8'sd0 && result.left_y == 8'sd0),
		"rotation and left stick both driven")
	`JAC_ASSERT_NOW(a_no_min_code, result_valid,
		result.left_x != -8'sd128 && result.left_y != -8'sd128 &&
		result.right_x != -8'sd128 && result.right_y != -8'sd128 &&
		result.rotation != -8'sd128,
		"axis output outside symmetric range")

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Joystick axis conditioner testbench
// Drives sample sets through the conditioner under several register settings
// and handshake pressures, predicts every result in fixed point and compares
// each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROTATE_BIT = 8;
	localparam int LIMIT_CYCLES = 20000000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_ready;
	jac_pkg::sample_t sample = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	jac_pkg::result_t result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [2:0]       cfg_index = jac_pkg::CFG_CENTER_LX;
	logic [15:0]      cfg_data = '0;

	// Register copies
	int unsigned center_q[4];
	int unsigned dead_q, expo_q, scale_q, hold_q;

	// History copies
	int          last_axes[5];
	logic [9:0]  btn_q;
	logic        sel_q[2];
	logic [31:0] sel_when[2];

	jac_pkg::result_t pending_results[$];
	int          err_count = 0;
	longint      cycle_count = 0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_request = 0;
	int          hold_taken = 0;
	int          hold_left = 0;
	logic [31:0] clock_ms = 0;

	joystick_axis_conditioner_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort on runaway
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// ---------------- fixed-point curve ----------------

	function automatic int unsigned frac_of_log2(longint unsigned mant);
		int unsigned f;
		f = 0;
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 16;
			f = f << 1;
			if (mant >= 64'h20000) begin
				f = f | 1;
				mant = mant >> 1;
			end
		end
		return f;
	endfunction

	function automatic longint unsigned mant_of_exp2(int unsigned f);
		longint unsigned lo, hi, mid;
		lo = 64'h10000;
		hi = 64'h1FFFF;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (frac_of_log2(mid) <= f) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint div_down(longint a, longint b);
		if (a >= 0) return a / b;
		return -((-a + b - 1) / b);
	endfunction

	function automatic int deflect_mag(int unsigned ad);
		longint          den, lg, pw, ip, fp;
		longint unsigned n, mant, v;
		int              k;
		den = 2048 - longint'(dead_q);
		if (den < 1) den = 1;
		if (scale_q == 0) return 0;
		if (expo_q == 0) return scale_q;
		n = (longint'(ad) << 16) / den;
		if (n == 0) return 0;
		k = 63;
		while (n[k] == 1'b0) k--;
		mant = (k >= 16) ? (n >> (k - 16)) : (n << (16 - k));
		lg = longint'(k - 16) * 65536 + frac_of_log2(mant);
		pw = div_down(lg * longint'(expo_q), 4096);
		ip = div_down(pw, 65536);
		fp = pw - ip * 65536;
		if (ip >= 7) return 127;
		if (ip <= -8) return 0;
		v = longint'(scale_q) * mant_of_exp2(int'(fp));
		if (ip >= 0) v = (v << ip) >> 16;
		else v = v >> (16 - ip);
		if (v > 127) v = 127;
		return int'(v);
	endfunction

	function automatic int shape_axis(logic [11:0] raw, int unsigned center);
		int dev, ad, mag;
		dev = int'(raw) - int'(center);
		ad = (dev < 0) ? -dev : dev;
		if (ad < dead_q) return 0;
		mag = deflect_mag(ad);
		return (dev > 0) ? mag : -mag;
	endfunction

	// Advance the history copy by one sample set and queue its result
	function automatic void predict_result(jac_pkg::sample_t s);
		int               lx, ly, rx, ry;
		int               axes[5];
		logic             rot, chg;
		jac_pkg::result_t r;
		lx = shape_axis(s.sample_left_x, center_q[0]);
		ly = -shape_axis(s.sample_left_y, center_q[1]);
		rx = shape_axis(s.sample_right_x, center_q[2]);
		ry = -shape_axis(s.sample_right_y, center_q[3]);
		chg = 1'b0;
		for (int j = 0; j < 2; j++) begin
			if (s.select_raw[j] != sel_q[j] &&
			    32'(s.time_ms - sel_when[j]) > hold_q) begin
				sel_q[j] = s.select_raw[j];
				sel_when[j] = s.time_ms;
				chg = 1'b1;
			end
		end
		rot = btn_q[ROTATE_BIT];
		axes[0] = rot ? 0 : lx;
		axes[1] = rot ? 0 : ly;
		axes[2] = rx;
		axes[3] = ry;
		axes[4] = rot ? lx : 0;
		if (s.buttons_raw != btn_q) chg = 1'b1;
		btn_q = s.buttons_raw;
		for (int j = 0; j < 5; j++) begin
			if (axes[j] != last_axes[j]) chg = 1'b1;
			last_axes[j] = axes[j];
		end
		r.left_x = 8'(axes[0]);
		r.left_y = 8'(axes[1]);
		r.right_x = 8'(axes[2]);
		r.right_y = 8'(axes[3]);
		r.rotation = 8'(axes[4]);
		r.buttons_out = btn_q;
		r.select_out = {sel_q[1], sel_q[0]};
		r.changed = chg;
		pending_results.push_back(r);
	endfunction

	// ---------------- checking ----------------

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		err_count++;
	endtask

	// Hold ready low for a requested stretch, else stall at random
	always @(posedge clk) begin
		if (hold_request != hold_taken) begin
			hold_taken = hold_request;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		jac_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.left_x !== want.left_x)
					report("left_x", result.left_x, want.left_x);
				if (result.left_y !== want.left_y)
					report("left_y", result.left_y, want.left_y);
				if (result.right_x !== want.right_x)
					report("right_x", result.right_x, want.right_x);
				if (result.right_y !== want.right_y)
					report("right_y", result.right_y, want.right_y);
				if (result.rotation !== want.rotation)
					report("rotation", result.rotation, want.rotation);
				if (result.buttons_out !== want.buttons_out)
					report("buttons_out", result.buttons_out, want.buttons_out);
				if (result.select_out !== want.select_out)
					report("select_out", result.select_out, want.select_out);
				if (result.changed !== want.changed)
					report("changed", result.changed, want.changed);
			end
		end
	end

	// ---------------- drivers ----------------

	// Offer one sample set, wait for its transfer, then predict it
	task automatic send_sample(jac_pkg::sample_t s);
		if ($urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		predict_result(s);
	endtask

	// Drop valid and wait until every result has arrived
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			jac_pkg::CFG_CENTER_LX: center_q[0] = value & 12'hFFF;
			jac_pkg::CFG_CENTER_LY: center_q[1] = value & 12'hFFF;
			jac_pkg::CFG_CENTER_RX: center_q[2] = value & 12'hFFF;
			jac_pkg::CFG_CENTER_RY: center_q[3] = value & 12'hFFF;
			jac_pkg::CFG_DEAD_BAND: dead_q = value & 11'h7FF;
			jac_pkg::CFG_CURVE_EXP: expo_q = value & 16'hFFFF;
			jac_pkg::CFG_OUT_SCALE: scale_q = value & 7'h7F;
			jac_pkg::CFG_HOLD_MS:   hold_q = value & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic apply_settings(int unsigned clx, int unsigned cly, int unsigned crx,
		int unsigned cry, int unsigned dead, int unsigned expo, int unsigned scale,
		int unsigned hold);
		write_reg(jac_pkg::CFG_CENTER_LX, clx);
		write_reg(jac_pkg::CFG_CENTER_LY, cly);
		write_reg(jac_pkg::CFG_CENTER_RX, crx);
		write_reg(jac_pkg::CFG_CENTER_RY, cry);
		write_reg(jac_pkg::CFG_DEAD_BAND, dead);
		write_reg(jac_pkg::CFG_CURVE_EXP, expo);
		write_reg(jac_pkg::CFG_OUT_SCALE, scale);
		write_reg(jac_pkg::CFG_HOLD_MS, hold);
	endtask

	function automatic jac_pkg::sample_t make_set(logic [11:0] v, logic [1:0] sel,
		logic [9:0] btn, logic [31:0] t);
		jac_pkg::sample_t s;
		s.sample_left_x = v;
		s.sample_left_y = v;
		s.sample_right_x = v;
		s.sample_right_y = v;
		s.select_raw = sel;
		s.buttons_raw = btn;
		s.time_ms = t;
		return s;
	endfunction

	// Axis reading: mostly anywhere, sometimes around the center or at a rail
	function automatic logic [11:0] pick_axis(int unsigned center);
		int v;
		case ($urandom_range(9))
			0, 1, 2: v = int'(center) + $urandom_range(200) - 100;
			3:       v = ($urandom_range(1) == 0) ? 0 : 4095;
			default: v = $urandom_range(4095);
		endcase
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return 12'(v);
	endfunction

	function automatic jac_pkg::sample_t random_set(ref logic [9:0] btn);
		jac_pkg::sample_t s;
		s.sample_left_x = pick_axis(center_q[0]);
		s.sample_left_y = pick_axis(center_q[1]);
		s.sample_right_x = pick_axis(center_q[2]);
		s.sample_right_y = pick_axis(center_q[3]);
		s.select_raw = 2'($urandom_range(3));
		// Keep buttons mostly steady so rotation mode lasts a while
		if ($urandom_range(3) == 0) btn = 10'($urandom_range(1023));
		s.buttons_raw = btn;
		if ($urandom_range(19) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + $urandom_range(80);
		s.time_ms = clock_ms;
		return s;
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		apply_settings(2048, 2048, 2048, 2048, 100, 4096, 127, 50);
		send_sample(make_set(12'd2048, 2'b00, 10'h000, 32'd0));
		send_sample(make_set(12'd0, 2'b11, 10'h000, 32'd10));
		send_sample(make_set(12'd4095, 2'b11, 10'h3FF, 32'd51));
		send_sample(make_set(12'd2147, 2'b00, 10'h100, 32'd101));
		send_sample(make_set(12'd2148, 2'b00, 10'h100, 32'd102));
		send_sample(make_set(12'd1948, 2'b00, 10'h000, 32'd200));
		send_sample(make_set(12'd1949, 2'b01, 10'h2AA, 32'hFFFF_FFF0));
		send_sample(make_set(12'd3000, 2'b10, 10'h155, 32'h0000_0030));
		drain();
		// Zero dead band with zero exponent: every axis reads full scale
		apply_settings(2048, 2048, 2048, 2048, 0, 0, 127, 0);
		send_sample(make_set(12'd2048, 2'b01, 10'h000, 32'd1));
		send_sample(make_set(12'd2049, 2'b10, 10'h100, 32'd1));
		send_sample(make_set(12'd0, 2'b00, 10'h000, 32'd1));
		drain();
		// Zero deviation on half the axes with a nonzero exponent, then zero scale
		apply_settings(0, 4095, 0, 4095, 0, 8192, 127, 65535);
		send_sample(make_set(12'd0, 2'b11, 10'h000, 32'd70000));
		send_sample(make_set(12'd4095, 2'b00, 10'h000, 32'd70001));
		drain();
		write_reg(jac_pkg::CFG_OUT_SCALE, 0);
		send_sample(make_set(12'd1000, 2'b00, 10'h3FF, 32'd2));
		drain();
		// Steepest curve, then the widest dead band
		apply_settings(2048, 2048, 2048, 2048, 1, 65535, 64, 50);
		send_sample(make_set(12'd4095, 2'b00, 10'h000, 32'd0));
		send_sample(make_set(12'd2049, 2'b00, 10'h000, 32'd0));
		send_sample(make_set(12'd0, 2'b00, 10'h000, 32'd0));
		drain();
		write_reg(jac_pkg::CFG_DEAD_BAND, 2047);
		write_reg(jac_pkg::CFG_CURVE_EXP, 1);
		send_sample(make_set(12'd1, 2'b00, 10'h000, 32'd0));
		send_sample(make_set(12'd4095, 2'b00, 10'h000, 32'd0));
		drain();
	endtask

	task automatic test_random(int items, int gap_pct, int stall_pct);
		logic [9:0] btn;
		btn = btn_q;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < items; i++) send_sample(random_set(btn));
		drain();
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		logic [9:0] btn;
		btn = btn_q;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_request++;
		for (int i = 0; i < 8; i++) send_sample(random_set(btn));
		drain();
	endtask

	task automatic random_settings();
		int unsigned expo;
		case ($urandom_range(3))
			0:       expo = $urandom_range(65535);
			1:       expo = 4096;
			default: expo = $urandom_range(1024, 16384);
		endcase
		apply_settings($urandom_range(1500, 2600), $urandom_range(1500, 2600),
			$urandom_range(4095), $urandom_range(1500, 2600), $urandom_range(400),
			expo, $urandom_range(127), $urandom_range(120));
	endtask

	initial begin
		center_q = '{2048, 2048, 2048, 2048};
		dead_q = 100;
		expo_q = 4096;
		scale_q = 127;
		hold_q = 50;
		last_axes = '{0, 0, 0, 0, 0};
		btn_q = '0;
		sel_q = '{1'b0, 1'b0};
		sel_when = '{32'd0, 32'd0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		apply_settings(2048, 2048, 2048, 2048, 100, 4096, 127, 50);
		test_random(250, 0, 0);
		random_settings();
		test_random(250, 59, 0);
		test_backpressure();
		random_settings();
		test_random(250, 0, 59);
		random_settings();
		test_random(250, 27, 27);
		apply_settings(4095, 0, 2048, 2048, 2047, 65535, 127, 65535);
		test_random(60, 0, 0);
		random_settings();
		test_random(200, 0, 0);
		if (err_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/jac_pkg.sv
hdl/jac_log2.sv
hdl/joystick_axis_conditioner_top.sv
test/testbench.sv
